// ===== hw/rtl/stmi_pkg.sv =====
// Package for the servo timed move interpolator.
// Holds widths, constants, action codes and the request structs that the modules share.
// Depends on nothing.
`timescale 1ns / 1ps

package stmi_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CHAN_W       = 3;
  localparam int WIDTH_W      = 12;
  localparam int MT_W         = 16;
  localparam int STEP_W       = 29;
  localparam int STEPS_W      = 12;
  localparam int FRAC_BITS    = 16;
  localparam int DIV_W        = 28;
  localparam int DIVR_W       = 12;
  localparam int PROD_W       = STEP_W + STEPS_W + 1;
  localparam int OFF_W        = PROD_W - FRAC_BITS;

  localparam logic [WIDTH_W-1:0] MID_WIDTH = WIDTH_W'(1500);
  localparam logic [WIDTH_W-1:0] MAX_WIDTH = WIDTH_W'(2500);
  localparam logic [DIVR_W-1:0]  TICK_MS   = DIVR_W'(20);
  localparam logic [MT_W-1:0]    MT_RESET  = MT_W'(2000);

  // move_time / 20 as (move_time * 52429) >> 20, exact over the 16-bit range
  localparam logic [15:0]        TICK_RECIP = 16'(52429);
  localparam int                 TICK_SHIFT = 20;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_FLD_W  = NUM_CHANNELS * WIDTH_W + 1;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_COMMIT = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     go;
    logic signed [STEP_W-1:0] step;
    logic [STEPS_W-1:0]       steps_left;
    logic [WIDTH_W-1:0]       target;
  } interp_req_t;

endpackage

// ===== hw/rtl/stmi_div.sv =====
// Shared iterative unsigned divider, one quotient bit per cycle.
// Used for every channel's step size.
// Depends on stmi_pkg.
`timescale 1ns / 1ps

module stmi_div import stmi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [DIV_W-1:0]  dvd;
  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] dvs;
  logic [DIVR_W:0]   trial;
  logic              fits;

  assign trial    = {rem, dvd[DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CNT_W'(DIV_W);
        dvd <= req.dividend;
        dvs <= req.divisor;
        rem <= '0;
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        dvd <= {dvd[DIV_W-2:0], fits};
        rem <= fits ? DIVR_W'(trial - {1'b0, dvs}) : trial[DIVR_W-1:0];
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/stmi_interp.sv =====
// Interpolation unit: registered step * steps_left, then truncate, add target, clamp.
// Result is valid the cycle after go.
// Depends on stmi_pkg.
`timescale 1ns / 1ps

module stmi_interp import stmi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  interp_req_t        req,
  output logic               done,
  output logic [WIDTH_W-1:0] width
);

  logic signed [PROD_W-1:0] prod;
  logic [WIDTH_W-1:0]       tgt;
  logic signed [PROD_W-1:0] prod_adj;
  logic signed [OFF_W-1:0]  off;
  logic signed [OFF_W+1:0]  sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req.go;
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= PROD_W'(req.step * $signed({1'b0, req.steps_left}));
      tgt  <= req.target;
    end
  end

  // truncate toward zero
  always_comb begin
    prod_adj = prod[PROD_W-1] ? prod + PROD_W'((1 << FRAC_BITS) - 1) : prod;
    off      = OFF_W'(prod_adj >>> FRAC_BITS);
    sum      = $signed({2'b00, OFF_W'(tgt)}) + (OFF_W+2)'(off);
    if (sum < 0) begin
      width = '0;
    end else if (sum > $signed((OFF_W+2)'(MAX_WIDTH))) begin
      width = MAX_WIDTH;
    end else begin
      width = sum[WIDTH_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/servo_timed_move_interpolator_core.sv =====
// Top level of the servo timed move interpolator: sequencer, channel state, APB register.
// Instantiates stmi_div and stmi_interp; depends on stmi_pkg.
//
// channel  dir  payload
// s_*      in   tuser: action; tdata: channel, width
// m_*      out  tdata: width_ch0..width_ch7, moving
// apb      in   reg 0 move_time_ms at 0x0
//
// Set-target and commit are handled in S_IDLE. An idle tick goes through S_OUT; a moving
// tick runs S_MUL and S_ACC per channel, then S_OUT. A tick that starts a move first runs
// S_CDIV in the shared divider for each channel; its step count comes from a reciprocal multiply at accept.
// s_tready is high only while the sequencer is idle. A finished result waits in the output
// register; a tick cannot finish while that register is still full. Reset is synchronous.
`timescale 1ns / 1ps

module servo_timed_move_interpolator_core import stmi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [2:0] channel, [14:3] width
  input  logic [1:0]            s_tuser,   // [1:0] action
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // 12 bits per width_ch0..7, then moving
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CDIV = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  state_t                   state;
  logic [MT_W-1:0]          move_time;
  logic [WIDTH_W-1:0]       current [NUM_CHANNELS];
  logic [WIDTH_W-1:0]       target  [NUM_CHANNELS];
  logic signed [STEP_W-1:0] step_size [NUM_CHANNELS];
  logic [STEPS_W-1:0]       steps_left;
  logic                     running;
  logic                     pending;
  logic [CH_W-1:0]          ch;
  logic                     neg;

  div_req_t                 div_req;
  logic                     div_done;
  logic [DIV_W-1:0]         div_q;
  interp_req_t              ireq;
  logic                     idone;
  logic [WIDTH_W-1:0]       iwidth;

  logic                     s_acc;
  action_t                  act;
  logic [CHAN_W-1:0]        s_chan;
  logic [WIDTH_W-1:0]       s_width;
  logic [WIDTH_W-1:0]       s_width_clamped;
  logic                     start_tick;
  logic [31:0]              steps_prod;
  logic [STEPS_W-1:0]       steps_raw;
  logic [STEPS_W-1:0]       steps_q;
  logic [STEPS_W-1:0]       steps_now;
  logic [CH_W-1:0]          ch_div;
  logic signed [WIDTH_W:0]  diff;
  logic [WIDTH_W-1:0]       mag;
  logic [OUT_DATA_W-1:0]    out_pack;
  logic                     cfg_wr;

  assign s_tready        = (state == S_IDLE);
  assign s_acc           = s_tvalid && s_tready;
  assign act             = action_t'(s_tuser);
  assign s_chan          = s_tdata[CHAN_W-1:0];
  assign s_width         = s_tdata[CHAN_W +: WIDTH_W];
  assign s_width_clamped = (s_width > MAX_WIDTH) ? MAX_WIDTH : s_width;
  assign start_tick      = s_acc && (act == ACT_TICK) && !running && pending;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, move_time} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_time <= MT_RESET;
    end else if (cfg_wr) begin
      move_time <= pwdata[MT_W-1:0];
    end
  end

  // step count: move_time / 20, at least 1
  assign steps_prod = 32'(move_time) * 32'(TICK_RECIP);
  assign steps_raw  = steps_prod[TICK_SHIFT +: STEPS_W];
  assign steps_q    = (steps_raw == '0) ? STEPS_W'(1) : steps_raw;

  // divider requests
  assign steps_now = (state == S_IDLE) ? steps_q : steps_left;
  assign ch_div    = (state == S_IDLE) ? '0 : CH_W'(ch + CH_W'(1));
  assign diff      = $signed({1'b0, current[ch_div]}) - $signed({1'b0, target[ch_div]});
  assign mag       = diff[WIDTH_W] ? WIDTH_W'(-diff) : diff[WIDTH_W-1:0];

  always_comb begin
    div_req = '0;
    if (start_tick || (div_done && (state == S_CDIV) && (ch != LAST_CH))) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'({mag, FRAC_BITS'(0)});
      div_req.divisor  = steps_now;
    end
  end

  always_comb begin
    ireq.go         = (state == S_MUL);
    ireq.step       = step_size[ch];
    ireq.steps_left = steps_left;
    ireq.target     = target[ch];
  end

  always_comb begin
    out_pack = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      out_pack[c*WIDTH_W +: WIDTH_W] = current[c];
    end
    out_pack[NUM_CHANNELS*WIDTH_W] = running;
  end

  stmi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  stmi_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .req   (ireq),
    .done  (idone),
    .width (iwidth)
  );

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      neg <= diff[WIDTH_W];
    end
    if ((state == S_CDIV) && div_done) begin
      step_size[ch] <= neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    end
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tdata <= out_pack;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      steps_left <= '0;
      running    <= 1'b0;
      pending    <= 1'b0;
      ch         <= '0;
      m_tvalid   <= 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        current[c] <= MID_WIDTH;
        target[c]  <= MID_WIDTH;
      end
    end else begin
      if ((state == S_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            case (act)
              ACT_SET: begin
                if ({2'b00, s_chan} < 5'(NUM_CHANNELS)) begin
                  target[CH_W'(s_chan)] <= s_width_clamped;
                end
              end
              ACT_COMMIT: pending <= 1'b1;
              ACT_TICK: begin
                if (start_tick) begin
                  pending    <= 1'b0;
                  steps_left <= steps_q;
                  ch         <= '0;
                  state      <= S_CDIV;
                end else if (running) begin
                  steps_left <= steps_left - STEPS_W'(1);
                  ch         <= '0;
                  state      <= S_MUL;
                end else begin
                  state <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_CDIV: begin
          if (div_done) begin
            if (ch == LAST_CH) begin
              running    <= 1'b1;
              steps_left <= steps_left - STEPS_W'(1);
              ch         <= '0;
              state      <= S_MUL;
            end else begin
              ch <= CH_W'(ch + CH_W'(1));
            end
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (idone) begin
            current[ch] <= (steps_left == '0) ? target[ch] : iwidth;
            if (ch == LAST_CH) begin
              if (steps_left == '0) begin
                running <= 1'b0;
              end
              state <= S_OUT;
            end else begin
              ch    <= CH_W'(ch + CH_W'(1));
              state <= S_MUL;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
